// ----- design/ptex_pkg.sv -----
package ptex_pkg;

    localparam int TEX_BITS = 7;

    // register stages from input item to result
    localparam int NS = 8;

    typedef enum logic [1:0] {
        KIND_GRASS = 2'd0,
        KIND_DIRT  = 2'd1,
        KIND_ROAD  = 2'd2,
        KIND_WOOD  = 2'd3
    } kind_t;

    // per-octave hash input
    typedef struct packed {
        logic [TEX_BITS-1:0] hx;
        logic [TEX_BITS-1:0] hy;
        logic [4:0]          seed;
    } hash_in_t;

    localparam logic [31:0] H_MX   = 32'd1619;
    localparam logic [31:0] H_MY   = 32'd31337;
    localparam logic [31:0] H_MS   = 32'd3791;
    localparam logic [31:0] H_C1   = 32'd15731;
    localparam logic [31:0] H_C2   = 32'd789221;
    localparam logic [31:0] H_C3   = 32'd1376312589;

    localparam logic [16:0] W_HALF = 17'd32768;
    localparam logic [16:0] W_0P3  = 17'd19661;
    localparam logic [16:0] W_0P2  = 17'd13107;
    localparam logic [16:0] W_0P4  = 17'd26214;
    localparam logic [16:0] W_0P85 = 17'd55706;
    localparam logic [16:0] W_0P78 = 17'd51118;

endpackage

// ----- design/ptex_hash.sv -----
// pipelined integer hash noise, four register stages, result as q2.30
module ptex_hash (
    input  logic                clk,
    input  logic                en,
    input  ptex_pkg::hash_in_t  hin,
    output logic signed [31:0]  noise
);
    logic [31:0] h0_reg, h0_next;
    logic [31:0] h1_reg, hsq_reg;
    logic [31:0] h2_reg, t_reg;
    logic [31:0] m_reg;

    // seed mix and shift-xor
    always_comb
    begin
        logic [31:0] a;
        a = {25'd0, hin.hx} * ptex_pkg::H_MX + {25'd0, hin.hy} * ptex_pkg::H_MY
          + {27'd0, hin.seed} * ptex_pkg::H_MS;
        h0_next = (a << 13) ^ a;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h0_reg  <= h0_next;
            h1_reg  <= h0_reg;
            hsq_reg <= h0_reg * h0_reg;
            h2_reg  <= h1_reg;
            t_reg   <= hsq_reg * ptex_pkg::H_C1 + ptex_pkg::H_C2;
            m_reg   <= (h2_reg * t_reg + ptex_pkg::H_C3) & 32'h7fffffff;
        end
    end

    assign noise = $signed(32'h4000_0000 - m_reg);
endmodule

// ----- design/procedural_texture_pixel.sv -----
// channel | signals                          | direction
// in      | in_valid in_ready kind x/y_coord | to block
// out     | out_valid out_ready red green blue | from block
// one item per cycle unless a stall at the output holds it; a fixed 8-stage pipeline
// the hash multiplier chain and the weight/gain multiplies set the depth
// rst_n clears all stage valid bits; payload registers are not reset
// a stall at the output holds every stage, so no item is lost or repeated
module procedural_texture_pixel (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [6:0] x_coord,
    input  logic [6:0] y_coord,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);
    logic [ptex_pkg::NS-1:0] vld_reg;
    logic          adv;
    logic [1:0]    k_reg [ptex_pkg::NS];
    logic [6:0]    x_reg [ptex_pkg::NS];
    logic [6:0]    y_reg [ptex_pkg::NS];

    assign adv      = !vld_reg[ptex_pkg::NS-1] || out_ready;
    assign in_ready = adv;

    // hash inputs per octave
    ptex_pkg::hash_in_t hi0, hi1, hi2;
    logic signed [31:0] n0, n1, n2;

    always_comb
    begin
        logic [4:0] sd;
        sd = (kind == ptex_pkg::KIND_GRASS) ? 5'd1 :
             (kind == ptex_pkg::KIND_DIRT)  ? 5'd10 :
             (kind == ptex_pkg::KIND_ROAD)  ? 5'd20 : 5'd30;
        if (kind == ptex_pkg::KIND_WOOD)
        begin
            hi0.hx = 7'((16'(x_coord) * 16'd171) >> 9);
            hi0.hy = {4'd0, y_coord[6:4]};
            hi1.hx = 7'((16'(x_coord) * 16'd171) >> 10);
            hi1.hy = {4'd0, y_coord[6:4]};
        end
        else
        begin
            hi0.hx = x_coord;
            hi0.hy = y_coord;
            hi1.hx = {1'b0, x_coord[6:1]};
            hi1.hy = {1'b0, y_coord[6:1]};
        end
        hi0.seed = sd;
        hi1.seed = sd + 5'd1;
        hi2.hx   = {2'b0, x_coord[6:2]};
        hi2.hy   = {2'b0, y_coord[6:2]};
        hi2.seed = sd + 5'd2;
    end

    ptex_hash u_h0 (.clk(clk), .en(adv), .hin(hi0), .noise(n0));
    ptex_hash u_h1 (.clk(clk), .en(adv), .hin(hi1), .noise(n1));
    ptex_hash u_h2 (.clk(clk), .en(adv), .hin(hi2), .noise(n2));

    // item sideband follows the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[ptex_pkg::NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg[0] <= kind;
            x_reg[0] <= x_coord;
            y_reg[0] <= y_coord;
            for (int i = 1; i < ptex_pkg::NS; i++)
            begin
                k_reg[i] <= k_reg[i-1];
                x_reg[i] <= x_reg[i-1];
                y_reg[i] <= y_reg[i-1];
            end
        end
    end

    // stage 5: weighted products (noise valid at stage index 3)
    logic signed [48:0] p0_reg, p1_reg, p2_reg;
    logic [16:0] w0, w1, w2;
    always_comb
    begin
        unique case (k_reg[3])
            ptex_pkg::KIND_GRASS, ptex_pkg::KIND_DIRT:
            begin
                w0 = ptex_pkg::W_HALF; w1 = ptex_pkg::W_0P3; w2 = ptex_pkg::W_0P2;
            end
            default:
            begin
                w0 = ptex_pkg::W_0P4; w1 = ptex_pkg::W_0P3; w2 = 17'd0;
            end
        endcase
    end

    // stage 6: sum and blend
    logic [16:0] nb_reg;
    logic signed [50:0] ssum;
    assign ssum = 51'(p0_reg) + 51'(p1_reg) + 51'(p2_reg);

    // stage 7: gains / wood base-edge
    logic [21:0] ga_reg, gb_reg, gc_reg;
    logic [16:0] be_reg;
    logic [16:0] n7_reg;
    logic [16:0] edge_w, base_w;
    logic [3:0]  pos5;
    logic [3:0]  edge_dist;
    assign pos5      = y_reg[5][3:0];
    assign edge_dist = pos5[3] ? (pos5 - 4'd8) : (4'd8 - pos5);
    assign edge_w    = 17'd49152 + 17'((5'd8 - {1'b0, edge_dist}) * 17'd2048);
    assign base_w    = y_reg[5][4] ? ptex_pkg::W_0P78 : ptex_pkg::W_0P85;

    // stage 8 combine
    logic [7:0] r_reg, g_reg, b_reg;
    logic [16:0] beg;
    logic [9:0]  rr, gg, bb;
    logic        spark, stripe, seam;
    logic [11:0] sp;
    logic [8:0]  sp8, q5;
    logic [6:0]  x6, y6;
    assign x6 = x_reg[6];
    assign y6 = y_reg[6];
    assign beg    = 17'((34'(be_reg) * 34'(n7_reg)) >> 16);
    assign sp     = 12'(x6) * 12'd7 + 12'(y6) * 12'd13;
    // multiple of 40: low three bits clear and the rest a multiple of five
    assign sp8    = sp[11:3];
    assign q5     = 9'((18'(sp8) * 18'd205) >> 10);
    assign spark  = (sp[2:0] == 3'd0) && (sp8 == q5 * 9'd5);
    assign stripe = (x6 >= 7'd60) && (x6 <= 7'd68) && !y6[4];
    assign seam   = (y6[3:0] == 4'd0) || (y6[3:0] == 4'd15);

    always_comb
    begin
        logic [8:0] wr, wg, wb;
        wr = 9'((25'(beg) * 25'd160) >> 16);
        wg = 9'((25'(beg) * 25'd105) >> 16);
        wb = 9'((25'(beg) * 25'd55) >> 16);
        rr = '0; gg = '0; bb = '0;
        unique case (k_reg[6])
            ptex_pkg::KIND_GRASS:
            begin
                rr = 10'd58 + 10'(ga_reg[21:16]) + (spark ? 10'd5 : 10'd0);
                gg = 10'd130 + 10'(gb_reg[21:16]) + (spark ? 10'd20 : 10'd0);
                bb = 10'd45 + 10'(gc_reg[21:16]);
            end
            ptex_pkg::KIND_DIRT:
            begin
                rr = 10'd120 + 10'(ga_reg[21:16]);
                gg = 10'd88 + 10'(gb_reg[21:16]);
                bb = 10'd55 + 10'(gc_reg[21:16]);
            end
            ptex_pkg::KIND_ROAD:
            begin
                rr = stripe ? 10'd210 : 10'd55 + 10'(gb_reg[21:16]);
                gg = rr;
                bb = rr;
            end
            ptex_pkg::KIND_WOOD:
            begin
                rr = seam ? 10'(wr >> 1) : 10'(wr);
                gg = seam ? 10'(wg >> 1) : 10'(wg);
                bb = seam ? 10'(wb >> 1) : 10'(wb);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg <= n0 * $signed({1'b0, w0});
            p1_reg <= n1 * $signed({1'b0, w1});
            p2_reg <= n2 * $signed({1'b0, w2});
            nb_reg <= 17'((ssum >>> 31) + 51'sd32768);
            n7_reg <= nb_reg;
            be_reg <= 17'((34'(base_w) * 34'(edge_w)) >> 16);
            unique case (k_reg[5])
                ptex_pkg::KIND_GRASS:
                begin
                    ga_reg <= 22'(nb_reg) * 22'd18;
                    gb_reg <= 22'(nb_reg) * 22'd25;
                    gc_reg <= 22'(nb_reg) * 22'd12;
                end
                ptex_pkg::KIND_DIRT:
                begin
                    ga_reg <= 22'(nb_reg) * 22'd30;
                    gb_reg <= 22'(nb_reg) * 22'd20;
                    gc_reg <= 22'(nb_reg) * 22'd12;
                end
                default:
                begin
                    ga_reg <= 22'(nb_reg) * 22'd20;
                    gb_reg <= 22'(nb_reg) * 22'd20;
                    gc_reg <= 22'(nb_reg) * 22'd20;
                end
            endcase
            r_reg <= (rr > 10'd255) ? 8'd255 : rr[7:0];
            g_reg <= (gg > 10'd255) ? 8'd255 : gg[7:0];
            b_reg <= (bb > 10'd255) ? 8'd255 : bb[7:0];
        end
    end

    assign out_valid = vld_reg[ptex_pkg::NS-1];
    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;

    // a held result stays valid and keeps its red and blue values
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(blue))
        else $error("result changed under stall");
    // stalls freeze the pipeline valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
    // road results are grey
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && k_reg[ptex_pkg::NS-1] == ptex_pkg::KIND_ROAD
        |-> red == green && green == blue)
        else $error("road texel not grey");
endmodule
